[rtl/core/sobel_gradient_direction_defines.svh]
// assertion macros shared by the sobel gradient rtl
`ifndef SOBEL_GRADIENT_DIRECTION_DEFINES_SVH
`define SOBEL_GRADIENT_DIRECTION_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SGD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sgd assertion failed");

// antecedent implies consequent in the next cycle
`define SGD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sgd assertion failed");

`else

`define SGD_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SGD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/core/sgd_pkg.sv]
// shared types and constants for the sobel gradient block
package sgd_pkg;

    localparam int PIXEL_W    = 8;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_W      = 12;
    localparam int THRESH_W   = 11;
    localparam int MIN_DIM    = 3;
    localparam int FIRST_INTERIOR = 2;

    typedef logic [PIXEL_W-1:0]     t_pixel;
    typedef logic [2:0][PIXEL_W-1:0] t_column;   // index is window row, 0 = top
    typedef logic [8:0][PIXEL_W-1:0] t_window;   // index is row * 3 + column
    typedef logic [2*PIXEL_W-1:0]   t_line_pair; // upper line in the high byte

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_index CFG_IMAGE_HEIGHT = 2'd1;
    localparam t_cfg_index CFG_THRESHOLD    = 2'd2;

    typedef enum logic [1:0] {
        DIR_WE = 2'd0,
        DIR_NE = 2'd1,
        DIR_N  = 2'd2,
        DIR_NW = 2'd3
    } t_direction;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctrl;

    // tan 22.5 and tan 67.5 in q16
    localparam int PROD_W = 28;
    localparam logic [17:0] TAN22_Q16 = 18'd27146;
    localparam logic [17:0] TAN67_Q16 = 18'd158218;

    // divide by six as multiply by round(2^18 / 6)
    localparam int QUOT_PROD_W  = 27;
    localparam int RECIP6_SHIFT = 18;
    localparam logic [15:0] RECIP6_Q18 = 16'd43691;
    localparam logic [7:0]  MAG_MAX    = 8'd255;

endpackage

[rtl/core/sgd_line_store.sv]
// two-row line store held as one memory of pixel pairs
module sgd_line_store
    import sgd_pkg::*;
#(
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_line_pair    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_line_pair    i_wr_data
);

    t_line_pair r_mem [DEPTH];
    t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/sgd_column_cell.sv]
// one column of the 3x3 window, loaded from its right-hand neighbour
module sgd_column_cell
    import sgd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_column i_column,
    output t_column o_column
);

    t_column r_column;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
        end else if (i_en) begin
            r_column <= i_column;
        end
    end

    assign o_column = r_column;

endmodule

[rtl/core/sgd_gradient.sv]
// sobel sums, l1 magnitude with threshold and divide, angle sector
module sgd_gradient
    import sgd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  t_ctrl          i_ctrl,
    input  t_window        i_window,
    input  logic [THRESH_W-1:0] i_threshold,
    output t_ctrl          o_ctrl,
    output logic [PIXEL_W-1:0] o_magnitude,
    output t_direction     o_direction
);

    // stage a: signed sobel sums
    logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
    t_ctrl              r_ctrl_a;
    logic signed [10:0] r_gx, r_gy;

    // stage b: absolute values, sum and angle products
    logic [9:0]         ax, ay;
    logic [10:0]        sum;
    t_ctrl              r_ctrl_b;
    logic [10:0]        r_sum;
    logic               r_above;
    logic [PROD_W-1:0]  r_k22, r_k67;
    logic [9:0]         r_ay;
    logic               r_gx_zero;
    logic               r_same;

    // stage c: output register
    logic [QUOT_PROD_W-1:0] quot_prod;
    logic [8:0]             quot;
    logic [PROD_W-1:0]      a_scaled;
    logic [PIXEL_W-1:0]     n_mag;
    t_direction             n_dir;
    t_ctrl                  r_ctrl_c;
    logic [PIXEL_W-1:0]     r_mag;
    t_direction             r_dir;

    always_comb begin
        gx_pos = 10'(i_window[2]) + {1'b0, i_window[5], 1'b0} + 10'(i_window[8]);
        gx_neg = 10'(i_window[0]) + {1'b0, i_window[3], 1'b0} + 10'(i_window[6]);
        gy_pos = 10'(i_window[0]) + {1'b0, i_window[1], 1'b0} + 10'(i_window[2]);
        gy_neg = 10'(i_window[6]) + {1'b0, i_window[7], 1'b0} + 10'(i_window[8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a <= '0;
            r_ctrl_b <= '0;
            r_ctrl_c <= '0;
        end else if (i_adv) begin
            r_ctrl_a <= i_ctrl;
            r_ctrl_b <= r_ctrl_a;
            r_ctrl_c <= r_ctrl_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_gx <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
            r_gy <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
        end
    end

    always_comb begin
        ax  = r_gx[10] ? 10'(-r_gx) : 10'(r_gx);
        ay  = r_gy[10] ? 10'(-r_gy) : 10'(r_gy);
        sum = 11'(ax) + 11'(ay);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum     <= sum;
            r_above   <= sum > i_threshold;
            r_k22     <= PROD_W'(ax) * PROD_W'(TAN22_Q16);
            r_k67     <= PROD_W'(ax) * PROD_W'(TAN67_Q16);
            r_ay      <= ay;
            r_gx_zero <= (r_gx == '0);
            r_same    <= (r_gx[10] == r_gy[10]);
        end
    end

    always_comb begin
        quot_prod = QUOT_PROD_W'(r_sum) * QUOT_PROD_W'(RECIP6_Q18);
        quot      = 9'(quot_prod >> RECIP6_SHIFT);
        if (!r_above) begin
            n_mag = '0;
        end else if (quot > 9'(MAG_MAX)) begin
            n_mag = MAG_MAX;
        end else begin
            n_mag = quot[PIXEL_W-1:0];
        end

        a_scaled = {2'b00, r_ay, 16'h0000};
        if (r_gx_zero || (a_scaled > r_k67)) begin
            n_dir = DIR_N;
        end else if (a_scaled <= r_k22) begin
            n_dir = DIR_WE;
        end else if (r_same) begin
            n_dir = DIR_NE;
        end else begin
            n_dir = DIR_NW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag <= n_mag;
            r_dir <= n_dir;
        end
    end

    assign o_ctrl      = r_ctrl_c;
    assign o_magnitude = r_mag;
    assign o_direction = r_dir;

endmodule

[rtl/core/sobel_gradient_direction.sv]
// sobel gradient magnitude and direction over a raster pixel stream
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  pixel in | i_in_valid / o_in_stall    | i_pixel
//  result   | o_out_valid / i_out_stall  | o_magnitude, o_edge_direction, o_frame_last
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one pixel per clock while the output is not stalled; a result leaves the output
// register after the pixel that completes its window passes the line store read,
// window cells, sobel sums, sum and angle products and output register
// the whole pipeline freezes while a held result is stalled, and the input
// stalls with it; the line store needs no clearing after reset
// synchronous active-low reset clears counters, window cells and valid flags, and loads default config
`include "sobel_gradient_direction_defines.svh"

module sobel_gradient_direction
    import sgd_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIXEL_W-1:0]    i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIXEL_W-1:0]    o_magnitude,
    output logic [1:0]            o_edge_direction,
    output logic                  o_frame_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_image_width;
    logic [ROW_W-1:0]      r_image_height;
    logic [THRESH_W-1:0]   r_threshold;

    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [AW-1:0]    col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [WW-1:0]    col_inc;
    logic [ROW_W:0]   row_inc;
    logic             col_wrap;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic             emit;
    logic             last;
    logic             adv;
    logic             in_acc;

    // read stage
    logic          r_v1;
    logic          r_emit1;
    logic          r_last1;
    logic [AW-1:0] r_col1;
    t_pixel        r_px1;
    t_line_pair    line_rd;
    logic          cell_en;

    t_ctrl   r_ctrl2;
    t_column new_column;
    t_column cell_out [3];
    t_column cell_in [3];
    t_window window;

    t_ctrl      grad_ctrl;
    t_direction grad_dir;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_DATA_W'(640);
            r_image_height <= ROW_W'(480);
            r_threshold    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[ROW_W-1:0];
                CFG_THRESHOLD:    r_threshold    <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position of the incoming pixel
    always_comb begin
        w_eff = WW'(r_image_width);
        if (w_eff < WW'(MIN_DIM)) begin
            w_eff = WW'(MIN_DIM);
        end
        if (w_eff > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end
        h_eff = (r_image_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : r_image_height;

        col_cur = (WW'(r_col) >= w_eff) ? '0 : r_col;
        row_cur = (r_row >= h_eff) ? '0 : r_row;

        col_inc  = WW'(col_cur) + WW'(1);
        row_inc  = {1'b0, row_cur} + (ROW_W + 1)'(1);
        col_wrap = (col_inc >= w_eff);
        n_col    = col_wrap ? '0 : col_inc[AW-1:0];
        if (!col_wrap) begin
            n_row = row_cur;
        end else if (row_inc >= {1'b0, h_eff}) begin
            n_row = '0;
        end else begin
            n_row = row_inc[ROW_W-1:0];
        end

        emit = (WW'(col_cur) >= WW'(FIRST_INTERIOR)) && (row_cur >= ROW_W'(FIRST_INTERIOR));
        last = (WW'(col_cur) == w_eff - WW'(1)) && (row_cur == h_eff - ROW_W'(1));
    end

    assign adv        = !(grad_ctrl.valid && i_out_stall);
    assign o_in_stall = !adv;
    assign in_acc     = i_in_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_ctrl2 <= '0;
        end else if (adv) begin
            r_v1          <= in_acc;
            r_ctrl2.valid <= r_v1 && r_emit1;
            r_ctrl2.last  <= r_last1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_emit1 <= emit;
            r_last1 <= last;
            r_col1  <= col_cur;
            r_px1   <= i_pixel;
        end
    end

    sgd_line_store #(
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (adv),
        .i_rd_addr (col_cur),
        .o_rd_data (line_rd),
        .i_wr_en   (cell_en),
        .i_wr_addr (r_col1),
        .i_wr_data ({line_rd[PIXEL_W-1:0], r_px1})
    );

    // the window shifts left by one column per transaction
    assign cell_en    = adv && r_v1;
    assign new_column = {r_px1, line_rd[PIXEL_W-1:0], line_rd[2*PIXEL_W-1:PIXEL_W]};

    for (genvar c = 0; c < 3; c++) begin : g_cells
        if (c == 2) begin : g_right
            assign cell_in[c] = new_column;
        end else begin : g_inner
            assign cell_in[c] = cell_out[c+1];
        end

        sgd_column_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (cell_en),
            .i_column (cell_in[c]),
            .o_column (cell_out[c])
        );

        for (genvar r = 0; r < 3; r++) begin : g_rows
            assign window[r*3+c] = cell_out[c][r];
        end
    end

    sgd_gradient u_gradient (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_ctrl      (r_ctrl2),
        .i_window    (window),
        .i_threshold (r_threshold),
        .o_ctrl      (grad_ctrl),
        .o_magnitude (o_magnitude),
        .o_direction (grad_dir)
    );

    assign o_out_valid      = grad_ctrl.valid;
    assign o_frame_last     = grad_ctrl.last;
    assign o_edge_direction = grad_dir;

    // end of frame brings the raster position back to the origin
    `SGD_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, in_acc && last, (r_col == '0) && (r_row == '0))
    // a frozen pipeline keeps its window
    `SGD_ASSERT_NEXT(a_window_hold, i_clk, i_rst_n, !adv, $stable(window))
    // no pixel taken while a result is held back
    `SGD_ASSERT_SAME(a_stall_back, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)

endmodule
